FILE: src/rotate_point_about_center_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point rotation block
// Helpers for concurrent checks, clocked on clk with reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ROTATE_POINT_ABOUT_CENTER_DEFINES_SVH
`define ROTATE_POINT_ABOUT_CENTER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define RPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define RPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RPC_ASSERT_NOW(label, ante, cons, msg)
`define RPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: src/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Widths, constants and stage payload types of the point rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

  // Number of CORDIC micro-rotations (8 to 24).
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_ITERS  =
    (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // Field and datapath widths.
  localparam int COORD_W     = 32;              // Q16.16 coordinates
  localparam int ANGLE_W     = 19;              // Q2.16 angle
  localparam int ANGLE_SHIFT = 14;              // Q2.16 to Q2.30
  localparam int PRE_W       = 34;              // scaled angle before folding
  localparam int Z_W         = 33;              // residual angle, Q2.30
  localparam int XY_W        = 32;              // CORDIC vector, Q1.30
  localparam int TRIG_W      = XY_W - 1;        // cosine and sine, Q2.28
  localparam int DIFF_W      = COORD_W + 1;     // exact point minus center
  localparam int PROD_W      = 64;              // products and their sums
  localparam int FRAC_SHIFT  = 28;              // drop the Q2.28 fraction
  localparam int SUM_W       = PROD_W - FRAC_SHIFT + 1;

  // CORDIC gain compensation and angle folding constants.
  localparam logic signed [XY_W-1:0]   GAIN_Q30    = 32'sd652032874;
  localparam logic signed [PRE_W-1:0]  PI_Q30      = 34'sd3373259426;
  localparam logic signed [PRE_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [PROD_W-1:0] ROUND_HALF  = 64'sd134217728;

  // Saturation bounds of a coordinate.
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // atan(2^-i) in Q2.30, truncated.
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // Input beat.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [ANGLE_W-1:0] turn_angle;
  } in_t;

  // After offset subtraction and angle folding.
  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [Z_W-1:0]     z;
    logic                      flip;
  } prep_t;

  // One CORDIC stage.
  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
    logic                      flip;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } cordic_t;

  // Rounded cosine and sine.
  typedef struct packed {
    logic signed [TRIG_W-1:0]  c;
    logic signed [TRIG_W-1:0]  s;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } trig_t;

  // The four partial products.
  typedef struct packed {
    logic signed [PROD_W-1:0]  xc;
    logic signed [PROD_W-1:0]  ys;
    logic signed [PROD_W-1:0]  xs;
    logic signed [PROD_W-1:0]  yc;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } prod_t;

  // Rotated offsets with the rounding half added.
  typedef struct packed {
    logic signed [PROD_W-1:0]  sx;
    logic signed [PROD_W-1:0]  sy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } sum_t;

  // Result beat.
  typedef struct packed {
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic                      overflow;
  } out_t;

endpackage

`default_nettype wire

FILE: src/rpc_in_if.sv
// ----------------------------------------------------------------------------
// rpc_in_if
// Input channel: valid/ready handshake carrying one point, center and angle.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_in_if;
  import rpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [ANGLE_W-1:0] turn_angle;

  modport source (
    output valid, point_x, point_y, center_x, center_y, turn_angle,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, center_x, center_y, turn_angle,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/rpc_out_if.sv
// ----------------------------------------------------------------------------
// rpc_out_if
// Result channel: valid/ready handshake carrying the rotated point.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_out_if;
  import rpc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rotated_x;
  logic signed [COORD_W-1:0] rotated_y;
  logic                      overflow;

  modport source (
    output valid, rotated_x, rotated_y, overflow,
    input  ready
  );

  modport sink (
    input  valid, rotated_x, rotated_y, overflow,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/rpc_prep.sv
// ----------------------------------------------------------------------------
// rpc_prep
// First pipeline stage: offset from the center and half-turn angle folding.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_prep (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output      logic           up_ready,
  input  wire rpc_pkg::in_t   up_data,
  output      logic           dn_valid,
  input  wire logic           dn_ready,
  output      rpc_pkg::prep_t dn_data
);
  import rpc_pkg::*;

  logic                    vld_r;
  prep_t                   data_r;
  prep_t                   data_nxt;
  logic signed [PRE_W-1:0] z_ext;
  logic signed [PRE_W-1:0] z_fold;

  // The stage takes a beat when it is empty or its content moves on.
  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  // Scale the angle to Q2.30 and fold it into plus or minus pi/2.
  always_comb begin
    z_ext         = PRE_W'(up_data.turn_angle) <<< ANGLE_SHIFT;
    z_fold        = z_ext;
    data_nxt.flip = 1'b0;
    priority if (z_ext > HALF_PI_Q30) begin
      z_fold        = z_ext - PI_Q30;
      data_nxt.flip = 1'b1;
    end else if (z_ext < -HALF_PI_Q30) begin
      z_fold        = z_ext + PI_Q30;
      data_nxt.flip = 1'b1;
    end else begin
      z_fold        = z_ext;
    end
    data_nxt.z  = Z_W'(z_fold);
    data_nxt.dx = DIFF_W'(up_data.point_x) - DIFF_W'(up_data.center_x);
    data_nxt.dy = DIFF_W'(up_data.point_y) - DIFF_W'(up_data.center_y);
    data_nxt.cx = up_data.center_x;
    data_nxt.cy = up_data.center_y;
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

`default_nettype wire

FILE: src/rpc_cordic.sv
// ----------------------------------------------------------------------------
// rpc_cordic
// Unrolled CORDIC in rotation mode: one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_cordic (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output      logic             up_ready,
  input  wire rpc_pkg::prep_t   up_data,
  output      logic             dn_valid,
  input  wire logic             dn_ready,
  output      rpc_pkg::cordic_t dn_data
);
  import rpc_pkg::*;

  cordic_t                 stg_r [CORDIC_ITERS];
  logic [CORDIC_ITERS-1:0] vld_r;
  logic [CORDIC_ITERS:0]   rdy;

  // Ready ripples back: a stage is free when empty or when it moves on.
  assign rdy[CORDIC_ITERS] = dn_ready;
  assign up_ready          = rdy[0];
  assign dn_valid          = vld_r[CORDIC_ITERS-1];
  assign dn_data           = stg_r[CORDIC_ITERS-1];

  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(ATAN_Q30[k]);

    cordic_t src;
    cordic_t stg_nxt;
    logic    src_v;

    assign rdy[k] = !vld_r[k] || rdy[k+1];

    // Stage zero starts from the gain-compensated unit vector.
    if (k == 0) begin : g_seed
      always_comb begin
        src.x    = GAIN_Q30;
        src.y    = '0;
        src.z    = up_data.z;
        src.flip = up_data.flip;
        src.dx   = up_data.dx;
        src.dy   = up_data.dy;
        src.cx   = up_data.cx;
        src.cy   = up_data.cy;
      end
      assign src_v = up_valid;
    end else begin : g_chain
      assign src   = stg_r[k-1];
      assign src_v = vld_r[k-1];
    end

    // Micro-rotation by atan(2^-k), direction from the residual's sign.
    always_comb begin
      stg_nxt = src;
      if (!src.z[Z_W-1]) begin
        stg_nxt.x = src.x - (src.y >>> k);
        stg_nxt.y = src.y + (src.x >>> k);
        stg_nxt.z = src.z - ATAN_K;
      end else begin
        stg_nxt.x = src.x + (src.y >>> k);
        stg_nxt.y = src.y - (src.x >>> k);
        stg_nxt.z = src.z + ATAN_K;
      end
    end

    // Stage valid bit.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_v;
      end
    end

    // Stage payload.
    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end
endmodule

`default_nettype wire

FILE: src/rpc_post.sv
// ----------------------------------------------------------------------------
// rpc_post
// Undoes the half-turn fold, rounds cosine and sine, multiplies, sums, re-centers and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_post (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output      logic             up_ready,
  input  wire rpc_pkg::cordic_t up_data,
  output      logic             dn_valid,
  input  wire logic             dn_ready,
  output      rpc_pkg::out_t    dn_data
);
  import rpc_pkg::*;

  logic                     trig_v_r, prod_v_r, sum_v_r, out_v_r;
  logic                     trig_rdy, prod_rdy, sum_rdy, out_rdy;
  trig_t                    trig_r, trig_nxt;
  prod_t                    prod_r, prod_nxt;
  sum_t                     sum_r, sum_nxt;
  out_t                     out_r, out_nxt;
  logic signed [XY_W:0]     cos_w, sin_w;
  logic signed [SUM_W-1:0]  full_x, full_y;
  logic                     sat_x, sat_y;

  // Ready chain over the four stages; the last one is the output register.
  assign out_rdy  = !out_v_r  || dn_ready;
  assign sum_rdy  = !sum_v_r  || out_rdy;
  assign prod_rdy = !prod_v_r || sum_rdy;
  assign trig_rdy = !trig_v_r || prod_rdy;
  assign up_ready = trig_rdy;
  assign dn_valid = out_v_r;
  assign dn_data  = out_r;

  // Undo the half-turn fold and round Q2.30 to Q2.28; -v + 2 is ~v + 3.
  always_comb begin
    if (up_data.flip) begin
      cos_w = ~(XY_W+1)'(up_data.x) + (XY_W+1)'(3);
      sin_w = ~(XY_W+1)'(up_data.y) + (XY_W+1)'(3);
    end else begin
      cos_w = (XY_W+1)'(up_data.x) + (XY_W+1)'(2);
      sin_w = (XY_W+1)'(up_data.y) + (XY_W+1)'(2);
    end
    trig_nxt.c  = cos_w[XY_W:2];
    trig_nxt.s  = sin_w[XY_W:2];
    trig_nxt.dx = up_data.dx;
    trig_nxt.dy = up_data.dy;
    trig_nxt.cx = up_data.cx;
    trig_nxt.cy = up_data.cy;
  end

  // Four independent 33 by 31 bit products.
  always_comb begin
    prod_nxt.xc = PROD_W'(trig_r.dx) * PROD_W'(trig_r.c);
    prod_nxt.ys = PROD_W'(trig_r.dy) * PROD_W'(trig_r.s);
    prod_nxt.xs = PROD_W'(trig_r.dx) * PROD_W'(trig_r.s);
    prod_nxt.yc = PROD_W'(trig_r.dy) * PROD_W'(trig_r.c);
    prod_nxt.cx = trig_r.cx;
    prod_nxt.cy = trig_r.cy;
  end

  // Rotation sums with the rounding half folded in.
  always_comb begin
    sum_nxt.sx = prod_r.xc - prod_r.ys + ROUND_HALF;
    sum_nxt.sy = prod_r.xs + prod_r.yc + ROUND_HALF;
    sum_nxt.cx = prod_r.cx;
    sum_nxt.cy = prod_r.cy;
  end

  // Drop the fraction, add the center back and clamp to 32 bits.
  always_comb begin
    full_x = SUM_W'($signed(sum_r.sx[PROD_W-1:FRAC_SHIFT])) + SUM_W'(sum_r.cx);
    full_y = SUM_W'($signed(sum_r.sy[PROD_W-1:FRAC_SHIFT])) + SUM_W'(sum_r.cy);
    sat_x  = (full_x > SUM_W'(COORD_MAX)) || (full_x < SUM_W'(COORD_MIN));
    sat_y  = (full_y > SUM_W'(COORD_MAX)) || (full_y < SUM_W'(COORD_MIN));
    if (sat_x) begin
      out_nxt.rotated_x = full_x[SUM_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      out_nxt.rotated_x = COORD_W'(full_x);
    end
    if (sat_y) begin
      out_nxt.rotated_y = full_y[SUM_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      out_nxt.rotated_y = COORD_W'(full_y);
    end
    out_nxt.overflow = sat_x || sat_y;
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_v_r <= 1'b0;
      prod_v_r <= 1'b0;
      sum_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (trig_rdy) begin
        trig_v_r <= up_valid;
      end
      if (prod_rdy) begin
        prod_v_r <= trig_v_r;
      end
      if (sum_rdy) begin
        sum_v_r <= prod_v_r;
      end
      if (out_rdy) begin
        out_v_r <= sum_v_r;
      end
    end
  end

  // Payload registers load only when a valid beat moves in.
  always_ff @(posedge clk) begin
    if (trig_rdy && up_valid) begin
      trig_r <= trig_nxt;
    end
    if (prod_rdy && trig_v_r) begin
      prod_r <= prod_nxt;
    end
    if (sum_rdy && prod_v_r) begin
      sum_r <= sum_nxt;
    end
    if (out_rdy && sum_v_r) begin
      out_r <= out_nxt;
    end
  end
endmodule

`default_nettype wire

FILE: src/rotate_point_about_center.sv
// ----------------------------------------------------------------------------
// rotate_point_about_center
// Rotates a Q16.16 point about a center by a Q2.16 angle using CORDIC.
// ----------------------------------------------------------------------------
// Usage:
// An input beat on in_ch carries point, center and angle; the result beat on
// out_ch carries the rotated point and an overflow flag set when either
// coordinate was clamped to the signed 32-bit range. Any angle code is
// honored; angles beyond pi/2 are folded by a half turn before the CORDIC.
// Path: the accepting edge loads the folding stage, then one stage per
// micro-rotation, then rounding, multiply, sum and output register stages,
// 21 register stages in all.
// Throughput: one beat per cycle while the receiver keeps out_ch.ready high.
// Every stage has its own valid bit and loads whenever it is empty or its
// content moves on, so bubbles close up and a new beat is taken while a
// finished result still waits in the output register. When the receiver holds
// out_ch.ready low the output beat stays put and the stages behind it fill;
// in_ch.ready falls only once every stage is occupied.
// Reset (rst_n low, synchronous) empties all stages; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rotate_point_about_center_defines.svh"

module rotate_point_about_center (
  input  wire logic clk,
  input  wire logic rst_n,
  rpc_in_if.sink    in_ch,
  rpc_out_if.source out_ch
);
  import rpc_pkg::*;

  in_t     in_data;
  logic    prep_v, cord_ready;
  prep_t   prep_d;
  logic    cord_v, post_ready;
  cordic_t cord_d;
  out_t    out_data;
  logic    out_clamped;

  // Gather the input beat.
  always_comb begin
    in_data.point_x    = in_ch.point_x;
    in_data.point_y    = in_ch.point_y;
    in_data.center_x   = in_ch.center_x;
    in_data.center_y   = in_ch.center_y;
    in_data.turn_angle = in_ch.turn_angle;
  end

  rpc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (in_data),
    .dn_valid (prep_v),
    .dn_ready (cord_ready),
    .dn_data  (prep_d)
  );

  rpc_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_v),
    .up_ready (cord_ready),
    .up_data  (prep_d),
    .dn_valid (cord_v),
    .dn_ready (post_ready),
    .dn_data  (cord_d)
  );

  rpc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cord_v),
    .up_ready (post_ready),
    .up_data  (cord_d),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (out_data)
  );

  // Spread the result beat onto the channel.
  assign out_ch.rotated_x = out_data.rotated_x;
  assign out_ch.rotated_y = out_data.rotated_y;
  assign out_ch.overflow  = out_data.overflow;

  // Either coordinate of the result beat sits on a clamp bound.
  assign out_clamped = (out_ch.rotated_x == COORD_MAX) || (out_ch.rotated_x == COORD_MIN) ||
                       (out_ch.rotated_y == COORD_MAX) || (out_ch.rotated_y == COORD_MIN);

  // A flagged result must carry a clamped coordinate.
  `RPC_ASSERT_NOW(a_ovf_clamped, out_ch.valid && out_ch.overflow, out_clamped, "unclamped overflow")
  // With the output register empty every stage can move, so input is open.
  `RPC_ASSERT_NOW(a_ready_when_drained, !out_ch.valid, in_ch.ready, "input blocked while drained")
  // A folded beat blocked by the CORDIC pipe must not disappear.
  `RPC_ASSERT_NEXT(a_prep_holds, prep_v && !cord_ready, prep_v, "stalled folding beat lost")
endmodule

`default_nettype wire

FILE: tb/sv/rpc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpc_checker
// Watches both channels of the point rotation block and checks every result.
// Each accepted input beat is run through a bit-exact model of the rotation:
// angle folding, gain-compensated CORDIC, rounding of sine and cosine, the
// rotated offset and saturation. The model's results wait in a queue. Each
// result beat is compared field by field with the oldest entry in that queue.
// ----------------------------------------------------------------------------

module rpc_checker (
  input  logic clk,
  input  logic rst_n,
  rpc_in_if    in_ch,
  rpc_out_if   out_ch,
  output int   mismatches,
  output int   points_in_flight
);
  import rpc_pkg::*;

  // The number of micro-rotations is capped by the length of the arctangent table.
  localparam int ARCTAN_LEN    = 24;
  localparam int CORDIC_PASSES =
    (CORDIC_STAGES < ARCTAN_LEN) ? CORDIC_STAGES : ARCTAN_LEN;

  localparam longint CORDIC_GAIN_Q30    = 64'sd652032874;
  localparam longint STRAIGHT_ANGLE_Q30 = 64'sd3373259426;
  localparam longint RIGHT_ANGLE_Q30    = 64'sd1686629713;
  localparam longint ROUND_HALF         = 64'sd134217728;
  localparam longint COORD_HI           = 64'sd2147483647;
  localparam longint COORD_LO           = -64'sd2147483648;

  // atan(2^-i) in Q2.30, truncated.
  localparam longint ARCTAN_Q30 [ARCTAN_LEN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  // Rotated points of the accepted beats, oldest first.
  out_t rotations_due [$];

  // Computes the rotated point and the overflow flag for one input beat.
  function automatic out_t rotate_expected(in_t p);
    longint px, py, cx, cy, ang, xv, yv, xs, ys, cs, sn, dx, dy, rx, ry;
    bit     flip;
    out_t   r;
    px  = $signed(p.point_x);
    py  = $signed(p.point_y);
    cx  = $signed(p.center_x);
    cy  = $signed(p.center_y);
    ang = $signed(p.turn_angle);
    ang = ang * 16384;
    flip = 1'b0;

    // A half turn brings the angle into the convergence range of the CORDIC.
    if (ang > RIGHT_ANGLE_Q30) begin
      ang  = ang - STRAIGHT_ANGLE_Q30;
      flip = 1'b1;
    end else if (ang < -RIGHT_ANGLE_Q30) begin
      ang  = ang + STRAIGHT_ANGLE_Q30;
      flip = 1'b1;
    end

    // Rotation mode, starting from the gain-compensated unit vector.
    xv = CORDIC_GAIN_Q30;
    yv = 0;
    for (int i = 0; i < CORDIC_PASSES; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (ang >= 0) begin
        xv  = xv - ys;
        yv  = yv + xs;
        ang = ang - ARCTAN_Q30[i];
      end else begin
        xv  = xv + ys;
        yv  = yv - xs;
        ang = ang + ARCTAN_Q30[i];
      end
    end
    if (flip) begin
      xv = -xv;
      yv = -yv;
    end

    // Cosine and sine rounded to Q2.28, then the offset is rotated and shifted back.
    cs = (xv + 2) >>> 2;
    sn = (yv + 2) >>> 2;
    dx = px - cx;
    dy = py - cy;
    rx = ((dx * cs - dy * sn + ROUND_HALF) >>> 28) + cx;
    ry = ((dx * sn + dy * cs + ROUND_HALF) >>> 28) + cy;

    r.overflow = 1'b0;
    if (rx > COORD_HI) begin
      rx = COORD_HI;
      r.overflow = 1'b1;
    end else if (rx < COORD_LO) begin
      rx = COORD_LO;
      r.overflow = 1'b1;
    end
    if (ry > COORD_HI) begin
      ry = COORD_HI;
      r.overflow = 1'b1;
    end else if (ry < COORD_LO) begin
      ry = COORD_LO;
      r.overflow = 1'b1;
    end
    r.rotated_x = rx[COORD_W-1:0];
    r.rotated_y = ry[COORD_W-1:0];
    return r;
  endfunction

  initial begin
    mismatches       = 0;
    points_in_flight = 0;
  end

  // Predict on every input beat and compare on every result beat.
  always @(posedge clk) begin
    in_t  taken;
    out_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken.point_x    = in_ch.point_x;
        taken.point_y    = in_ch.point_y;
        taken.center_x   = in_ch.center_x;
        taken.center_y   = in_ch.center_y;
        taken.turn_angle = in_ch.turn_angle;
        rotations_due.push_back(rotate_expected(taken));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (rotations_due.size() == 0) begin
          $error("result beat with nothing pending: rotated_x %0d, rotated_y %0d",
                 out_ch.rotated_x, out_ch.rotated_y);
          mismatches = mismatches + 1;
        end else begin
          want = rotations_due.pop_front();
          if (out_ch.rotated_x !== want.rotated_x) begin
            $error("rotated_x: expected %0d, got %0d", want.rotated_x, out_ch.rotated_x);
            mismatches = mismatches + 1;
          end
          if (out_ch.rotated_y !== want.rotated_y) begin
            $error("rotated_y: expected %0d, got %0d", want.rotated_y, out_ch.rotated_y);
            mismatches = mismatches + 1;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_ch.overflow);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    points_in_flight <= rotations_due.size();
  end

endmodule

FILE: tb/sv/rotate_point_about_center_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_point_about_center_tb
// Stimulus and verdict for the point rotation block.
// A directed set covers the extreme coordinates and saturation. It also
// covers angles at and beyond a right angle, at and beyond a half turn, and
// at the ends of the angle code. A random stream follows with mostly nearby
// point and center pairs, some fully random beats and some near the limits.
// Both sides hold off at random, with stretches at full rate. The checker
// beside the block predicts and compares each result.
// ----------------------------------------------------------------------------

module rotate_point_about_center_tb;
  import rpc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_POINTS = 750;
  localparam int SETTLE_CYCLES = CORDIC_STAGES + 12;

  localparam int COORD_TOP    = 32'sh7FFF_FFFF;
  localparam int COORD_BOTTOM = 32'sh8000_0000;
  localparam int UNIT         = 65536;          // 1.0 in Q16.16
  localparam int HALF_TURN    = 205887;         // pi in Q2.16
  localparam int PAST_RIGHT   = 102944;         // first code above pi/2
  localparam int BELOW_RIGHT  = 102943;         // last code below pi/2
  localparam int EIGHTH_TURN  = 51472;          // pi/4 in Q2.16
  localparam int ANGLE_TOP    = 262143;         // largest 19-bit code
  localparam int ANGLE_BOTTOM = -262144;        // smallest 19-bit code

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   mismatches;
  int   points_in_flight;
  bit   steady_feed;
  bit   steady_drain;
  int   drain_stall;
  int   drain_beats;

  rpc_in_if  in_ch ();
  rpc_out_if out_ch ();

  rotate_point_about_center dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rpc_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .mismatches       (mismatches),
    .points_in_flight (points_in_flight)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: after each beat, hold ready low for a random stall, none while draining steadily.
  always @(posedge clk) begin
    logic ready_next;
    if (!rst_n) begin
      ready_next = 1'b0;
    end else if (drain_stall > 0) begin
      drain_stall = drain_stall - 1;
      ready_next  = 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      drain_beats = drain_beats + 1;
      if (drain_beats % 50 == 0) begin
        steady_drain = ($urandom_range(0, 3) == 0);
      end
      drain_stall = steady_drain ? 0 : $urandom_range(0, 3);
      ready_next  = (drain_stall == 0);
      if (drain_stall > 0) begin
        drain_stall = drain_stall - 1;
      end
    end else begin
      ready_next = 1'b1;
    end
    out_ch.ready <= ready_next;
  end

  // Sends one beat after a random gap, none while feeding steadily, and returns at its acceptance.
  task automatic send_point(input int px, input int py, input int cx, input int cy,
                            input int angle);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= px;
    in_ch.point_y    <= py;
    in_ch.center_x   <= cx;
    in_ch.center_y   <= cy;
    in_ch.turn_angle <= ANGLE_W'(angle);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops sending until every pending rotation has come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (points_in_flight != 0) @(posedge clk);
  endtask

  // A coordinate close to one of the limits, or anywhere.
  function automatic int near_limit_coord();
    case ($urandom_range(0, 2))
      0:       return COORD_TOP - int'($urandom_range(0, 1 << 20));
      1:       return COORD_BOTTOM + int'($urandom_range(0, 1 << 20));
      default: return int'($urandom);
    endcase
  endfunction

  // Mostly within a half turn either way, sometimes any code, sometimes zero or a folding boundary.
  function automatic int pick_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      return int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
    end else if (sel == 8) begin
      return int'($urandom_range(0, ANGLE_TOP - ANGLE_BOTTOM)) + ANGLE_BOTTOM;
    end
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return PAST_RIGHT;
      2:       return -PAST_RIGHT;
      3:       return BELOW_RIGHT;
      4:       return -BELOW_RIGHT;
      5:       return HALF_TURN;
      default: return -HALF_TURN;
    endcase
  endfunction

  initial begin
    int sel;
    int cx;
    int cy;
    int offset_x;
    int offset_y;
    cycle_count      = 0;
    steady_feed      = 1'b0;
    steady_drain     = 1'b0;
    drain_stall      = 0;
    drain_beats      = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.point_x    = '0;
    in_ch.point_y    = '0;
    in_ch.center_x   = '0;
    in_ch.center_y   = '0;
    in_ch.turn_angle = '0;
    out_ch.ready     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats: zero, unit vectors, folding boundaries and the angle code ends.
    send_point(0, 0, 0, 0, 0);
    send_point(UNIT, 0, 0, 0, 0);
    send_point(UNIT, 0, 0, 0, PAST_RIGHT);
    send_point(UNIT, 0, 0, 0, BELOW_RIGHT);
    send_point(0, UNIT, 0, 0, -PAST_RIGHT);
    send_point(0, UNIT, 0, 0, -BELOW_RIGHT);
    send_point(UNIT, UNIT, -UNIT, 3 * UNIT, HALF_TURN);
    send_point(UNIT, -UNIT, 5 * UNIT, -UNIT, -HALF_TURN);
    send_point(7 * UNIT, 2 * UNIT, UNIT, UNIT, ANGLE_TOP);
    send_point(-7 * UNIT, 2 * UNIT, UNIT, -UNIT, ANGLE_BOTTOM);
    // Largest offsets, with and without saturation.
    send_point(COORD_TOP, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, 0);
    send_point(COORD_TOP, 0, COORD_BOTTOM, 0, HALF_TURN);
    send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, COORD_TOP, PAST_RIGHT);
    send_point(COORD_TOP, COORD_TOP, 0, 0, EIGHTH_TURN);
    send_point(COORD_BOTTOM, COORD_BOTTOM, 0, 0, EIGHTH_TURN);
    send_point(COORD_TOP, COORD_TOP, 0, 0, HALF_TURN);
    // Point on the center: the center comes back unchanged. Then small offsets.
    send_point(COORD_TOP, COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, -EIGHTH_TURN);
    send_point(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, COORD_TOP, ANGLE_TOP);
    send_point(-1, -1, 0, 0, -1);
    send_point(1, 1, 0, 0, 1);
    send_point(-3 * UNIT, -5 * UNIT, -UNIT, -UNIT, -EIGHTH_TURN);
    wait_for_drain();

    // Random beats, mostly a point near its center.
    for (int k = 0; k < RANDOM_POINTS; k++) begin
      if (k % 60 == 0) begin
        steady_feed = ($urandom_range(0, 3) == 0);
      end
      if (k == RANDOM_POINTS / 2) begin
        wait_for_drain();
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        cx       = int'($urandom) >>> $urandom_range(1, 16);
        cy       = int'($urandom) >>> $urandom_range(1, 16);
        offset_x = int'($urandom) >>> $urandom_range(6, 24);
        offset_y = int'($urandom) >>> $urandom_range(6, 24);
        send_point(cx + offset_x, cy + offset_y, cx, cy, pick_angle());
      end else if (sel < 8) begin
        send_point(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                   pick_angle());
      end else begin
        send_point(near_limit_coord(), near_limit_coord(), near_limit_coord(),
                   near_limit_coord(), pick_angle());
      end
    end
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
